[rtl/bffla_pkg.sv]
// Shared types and constants of the best-fit free-list allocator.
package bffla_pkg;

    localparam int ADDR_BITS_DEF       = 20;
    localparam int FREE_SLOTS_DEF      = 32;
    localparam int LIVE_SLOTS_DEF      = 32;
    localparam int HEADER_BYTES_DEF    = 8;
    localparam int MIN_ALLOC_BYTES_DEF = 16;

    localparam int MIN_ALIGN_LOG2 = 3;
    localparam int MAX_ALIGN_LOG2 = 12;
    localparam int REGION_RESET   = 65536;

    localparam int KIND_W   = 2;
    localparam int ALIGN_W  = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_SPARE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_BAD_REQ = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ALC_SCAN,
        S_ALC_COMMIT,
        S_SHIFT,
        S_FRE_LOOK,
        S_FRE_FINDP,
        S_FRE_DECIDE,
        S_FRE_INS,
        S_DONE
    } t_state;

endpackage

[rtl/bffla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bffla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/best_fit_free_list_allocator.sv]
// Best-fit free-list allocator with address-ordered free table and coalescing.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_kind, i_request_size, i_align_log2,
//           |           |                         | i_address
//  out      | output    | o_out_valid/i_out_stall | o_status, o_data_offset, o_block_bytes,
//           |           |                         | o_used_bytes, o_peak_bytes
//  cfg      | input     | i_cfg_wr_en             | i_cfg_wr_data (region size)
//
// One transaction is worked on at a time. An allocate runs the best-fit scan, then one
// commit state and one finish state; an exact fit adds a shift of the free table to close
// the gap. A free runs the live-table lookup, the neighbor search and one decide state,
// then, where needed, a shift and one more state to insert a new segment. Reset
// (synchronous) and a reset transaction each write free entry 0. A finished result waits
// in the output register while stalled.
module best_fit_free_list_allocator
#(
    parameter int ADDR_BITS       = bffla_pkg::ADDR_BITS_DEF,
    parameter int FREE_SLOTS      = bffla_pkg::FREE_SLOTS_DEF,
    parameter int LIVE_SLOTS      = bffla_pkg::LIVE_SLOTS_DEF,
    parameter int HEADER_BYTES    = bffla_pkg::HEADER_BYTES_DEF,
    parameter int MIN_ALLOC_BYTES = bffla_pkg::MIN_ALLOC_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ADDR_BITS:0]              i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bffla_pkg::KIND_W-1:0]    i_kind,
    input  logic [ADDR_BITS:0]              i_request_size,
    input  logic [bffla_pkg::ALIGN_W-1:0]   i_align_log2,
    input  logic [ADDR_BITS-1:0]            i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bffla_pkg::STATUS_W-1:0]  o_status,
    output logic [ADDR_BITS-1:0]            o_data_offset,
    output logic [ADDR_BITS:0]              o_block_bytes,
    output logic [ADDR_BITS:0]              o_used_bytes,
    output logic [ADDR_BITS:0]              o_peak_bytes
);
    import bffla_pkg::*;

    localparam int AW    = ADDR_BITS;
    localparam int SW    = ADDR_BITS + 1;
    localparam int CW    = ((SW > 13) ? SW : 13) + 2;
    localparam int FIW   = $clog2(FREE_SLOTS);
    localparam int LIW   = $clog2(LIVE_SLOTS);
    localparam int CNTW  = $clog2(FREE_SLOTS + 1);
    localparam int PW    = $clog2(((FREE_SLOTS > LIVE_SLOTS) ? FREE_SLOTS : LIVE_SLOTS) + 1);
    localparam int FE_W  = AW + SW;
    localparam int LE_W  = AW + AW + SW;

    // Control registers
    t_state              r_state, n_state;
    logic [SW-1:0]       r_region;
    logic [CNTW-1:0]     r_free_cnt, n_free_cnt;
    logic [LIVE_SLOTS-1:0] r_live_vld, n_live_vld;
    logic [SW-1:0]       r_used, n_used;
    logic [SW-1:0]       r_peak, n_peak;
    logic                r_out_valid, n_out_valid;
    logic                r_v1, n_v1;
    logic                r_v2, n_v2;
    logic                r_v3, n_v3;
    logic                r_from_item, n_from_item;

    // Working registers
    logic [SW-1:0]       r_size, n_size;
    logic [CW-1:0]       r_amask, n_amask;
    logic [AW-1:0]       r_addr, n_addr;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [PW-1:0]       r_ridx, n_ridx;
    logic [PW-1:0]       r_left, n_left;
    logic                r_up, n_up;
    logic [FIW-1:0]      r_s2_idx, n_s2_idx;
    logic [AW-1:0]       r_s2_base, n_s2_base;
    logic [SW-1:0]       r_s2_len, n_s2_len;
    logic [CW-1:0]       r_s2_align, n_s2_align;
    logic [FIW-1:0]      r_s3_idx, n_s3_idx;
    logic [AW-1:0]       r_s3_base, n_s3_base;
    logic [SW-1:0]       r_s3_len, n_s3_len;
    logic [CW-1:0]       r_s3_align, n_s3_align;
    logic [CW-1:0]       r_s3_need, n_s3_need;
    logic                r_found, n_found;
    logic [FIW-1:0]      r_b_idx, n_b_idx;
    logic [AW-1:0]       r_b_base, n_b_base;
    logic [AW-1:0]       r_b_align, n_b_align;
    logic [SW-1:0]       r_b_need, n_b_need;
    logic [SW-1:0]       r_b_rest, n_b_rest;
    logic [LIW-1:0]      r_slot, n_slot;
    logic [AW-1:0]       r_blk_base, n_blk_base;
    logic [SW-1:0]       r_blk_len, n_blk_len;
    logic                r_pdone, n_pdone;
    logic                r_have_prev, n_have_prev;
    logic                r_have_next, n_have_next;
    logic [CNTW-1:0]     r_p, n_p;
    logic [AW-1:0]       r_prev_base, n_prev_base;
    logic [SW-1:0]       r_prev_len, n_prev_len;
    logic [AW-1:0]       r_next_base, n_next_base;
    logic [SW-1:0]       r_next_len, n_next_len;
    t_status             r_res_status, n_res_status;
    logic [AW-1:0]       r_res_offset, n_res_offset;
    logic [SW-1:0]       r_res_bytes, n_res_bytes;
    t_status             r_o_status, n_o_status;
    logic [AW-1:0]       r_o_offset, n_o_offset;
    logic [SW-1:0]       r_o_bytes, n_o_bytes;
    logic [SW-1:0]       r_o_used, n_o_used;
    logic [SW-1:0]       r_o_peak, n_o_peak;

    // RAM ports
    logic                fr_we;
    logic [FIW-1:0]      fr_wa, fr_ra;
    logic [FE_W-1:0]     fr_wd, fr_rd;
    logic                lv_we;
    logic [LIW-1:0]      lv_wa, lv_ra;
    logic [LE_W-1:0]     lv_wd, lv_rd;

    // Datapath helpers
    logic [SW-1:0]       c_span, c_clip;
    logic [AW-1:0]       c_fr_base;
    logic [SW-1:0]       c_fr_len;
    logic [AW-1:0]       c_lv_off, c_lv_base;
    logic [SW-1:0]       c_lv_len;
    logic [CW-1:0]       c_align;
    logic [CW-1:0]       c_need;
    logic                c_fit;
    logic [SW-1:0]       c_rest;
    logic                c_join_prev, c_join_next;
    logic [SW-1:0]       c_used_sub;
    logic [SW-1:0]       c_peak_max;
    logic                c_slot_avail;
    logic [LIW-1:0]      c_free_slot;
    logic                c_bad_req;
    logic [CW-1:0]       c_amask;
    logic                c_issue;

    bffla_ram #(.WIDTH(FE_W), .DEPTH(FREE_SLOTS)) u_free_ram (
        .i_clk     (i_clk),
        .i_we      (fr_we),
        .i_wr_addr (fr_wa),
        .i_wr_data (fr_wd),
        .i_rd_addr (fr_ra),
        .o_rd_data (fr_rd)
    );

    bffla_ram #(.WIDTH(LE_W), .DEPTH(LIVE_SLOTS)) u_live_ram (
        .i_clk     (i_clk),
        .i_we      (lv_we),
        .i_wr_addr (lv_wa),
        .i_wr_data (lv_wd),
        .i_rd_addr (lv_ra),
        .o_rd_data (lv_rd)
    );

    assign c_span = SW'(1) << AW;
    assign c_clip = (r_region > c_span) ? c_span : r_region;

    assign c_fr_base = fr_rd[FE_W-1 -: AW];
    assign c_fr_len  = fr_rd[SW-1:0];
    assign c_lv_off  = lv_rd[LE_W-1 -: AW];
    assign c_lv_base = lv_rd[SW+AW-1 -: AW];
    assign c_lv_len  = lv_rd[SW-1:0];

    // Best-fit pipeline: aligned data offset, then block size, then fit and leftover.
    assign c_align = (CW'(c_fr_base) + CW'(HEADER_BYTES) + r_amask) & ~r_amask;
    assign c_need  = CW'(r_size) + r_s2_align - CW'(r_s2_base);
    assign c_fit   = CW'(r_s3_len) >= r_s3_need;
    assign c_rest  = r_s3_len - SW'(r_s3_need);

    assign c_join_prev = r_have_prev &&
                         ((SW'(r_prev_base) + r_prev_len) == SW'(r_blk_base));
    assign c_join_next = r_have_next &&
                         ((SW'(r_blk_base) + r_blk_len) == SW'(r_next_base));
    assign c_used_sub  = (r_used >= r_blk_len) ? (r_used - r_blk_len) : '0;
    assign c_peak_max  = (r_used > r_peak) ? r_used : r_peak;

    assign c_bad_req = (i_request_size < SW'(MIN_ALLOC_BYTES)) ||
                       (i_align_log2 > ALIGN_W'(MAX_ALIGN_LOG2));
    assign c_amask   = (i_align_log2 < ALIGN_W'(MIN_ALIGN_LOG2)) ?
                       ((CW'(1) << MIN_ALIGN_LOG2) - CW'(1)) :
                       ((CW'(1) << i_align_log2) - CW'(1));

    // Lowest free live slot.
    always_comb begin
        c_slot_avail = 1'b0;
        c_free_slot  = '0;
        for (int k = LIVE_SLOTS - 1; k >= 0; k--) begin
            if (!r_live_vld[k]) begin
                c_slot_avail = 1'b1;
                c_free_slot  = LIW'(k);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free_cnt   = r_free_cnt;
        n_live_vld   = r_live_vld;
        n_used       = r_used;
        n_peak       = r_peak;
        n_out_valid  = r_out_valid && i_out_stall;
        n_v1         = 1'b0;
        n_v2         = 1'b0;
        n_v3         = 1'b0;
        n_from_item  = r_from_item;
        n_size       = r_size;
        n_amask      = r_amask;
        n_addr       = r_addr;
        n_ptr        = r_ptr;
        n_ridx       = r_ptr;
        n_left       = r_left;
        n_up         = r_up;
        n_s2_idx     = r_ridx[FIW-1:0];
        n_s2_base    = c_fr_base;
        n_s2_len     = c_fr_len;
        n_s2_align   = c_align;
        n_s3_idx     = r_s2_idx;
        n_s3_base    = r_s2_base;
        n_s3_len     = r_s2_len;
        n_s3_align   = r_s2_align;
        n_s3_need    = c_need;
        n_found      = r_found;
        n_b_idx      = r_b_idx;
        n_b_base     = r_b_base;
        n_b_align    = r_b_align;
        n_b_need     = r_b_need;
        n_b_rest     = r_b_rest;
        n_slot       = r_slot;
        n_blk_base   = r_blk_base;
        n_blk_len    = r_blk_len;
        n_pdone      = r_pdone;
        n_have_prev  = r_have_prev;
        n_have_next  = r_have_next;
        n_p          = r_p;
        n_prev_base  = r_prev_base;
        n_prev_len   = r_prev_len;
        n_next_base  = r_next_base;
        n_next_len   = r_next_len;
        n_res_status = r_res_status;
        n_res_offset = r_res_offset;
        n_res_bytes  = r_res_bytes;
        n_o_status   = r_o_status;
        n_o_offset   = r_o_offset;
        n_o_bytes    = r_o_bytes;
        n_o_used     = r_o_used;
        n_o_peak     = r_o_peak;
        fr_we        = 1'b0;
        fr_wa        = '0;
        fr_wd        = '0;
        fr_ra        = r_ptr[FIW-1:0];
        lv_we        = 1'b0;
        lv_wa        = c_free_slot;
        lv_wd        = {r_b_align, r_b_base, r_b_need};
        lv_ra        = r_ptr[LIW-1:0];
        c_issue      = 1'b0;

        unique case (r_state)
            S_INIT: begin
                fr_we        = 1'b1;
                fr_wa        = '0;
                fr_wd        = {AW'(0), c_clip};
                n_free_cnt   = (c_clip != '0) ? CNTW'(1) : '0;
                n_live_vld   = '0;
                n_used       = '0;
                n_peak       = '0;
                n_res_status = ST_OK;
                n_res_offset = '0;
                n_res_bytes  = '0;
                n_state      = r_from_item ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_size       = i_request_size;
                    n_addr       = i_address;
                    n_amask      = c_amask;
                    n_ptr        = '0;
                    n_found      = 1'b0;
                    n_pdone      = 1'b0;
                    n_have_prev  = 1'b0;
                    n_have_next  = 1'b0;
                    n_p          = '0;
                    n_res_status = ST_OK;
                    n_res_offset = '0;
                    n_res_bytes  = '0;
                    unique case (t_kind'(i_kind))
                        KIND_ALLOC: begin
                            if (c_bad_req) begin
                                n_res_status = ST_BAD_REQ;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_ALC_SCAN;
                            end
                        end
                        KIND_FREE: begin
                            n_state = S_FRE_LOOK;
                        end
                        KIND_RESET: begin
                            n_from_item = 1'b1;
                            n_state     = S_INIT;
                        end
                        KIND_SPARE: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALC_SCAN: begin
                c_issue = r_ptr < PW'(r_free_cnt);
                if (c_issue) begin
                    n_ptr = r_ptr + PW'(1);
                    n_v1  = 1'b1;
                end
                n_v2 = r_v1;
                n_v3 = r_v2;
                if (r_v3 && c_fit && (!r_found || (c_rest < r_b_rest))) begin
                    n_found   = 1'b1;
                    n_b_idx   = r_s3_idx;
                    n_b_base  = r_s3_base;
                    n_b_align = AW'(r_s3_align);
                    n_b_need  = SW'(r_s3_need);
                    n_b_rest  = c_rest;
                end
                if (!c_issue && !r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_ALC_COMMIT;
                end
            end
            S_ALC_COMMIT: begin
                if (!r_found) begin
                    n_res_status = ST_NO_FIT;
                    n_state      = S_DONE;
                end else if (!c_slot_avail) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    lv_we                   = 1'b1;
                    n_live_vld[c_free_slot] = 1'b1;
                    n_used                  = r_used + r_b_need;
                    n_res_offset            = r_b_align;
                    n_res_bytes             = r_b_need;
                    if (r_b_rest != '0) begin
                        fr_we   = 1'b1;
                        fr_wa   = r_b_idx;
                        fr_wd   = {r_b_base + AW'(r_b_need), r_b_rest};
                        n_state = S_DONE;
                    end else begin
                        // Exact fit: close the gap left by the used segment.
                        n_ptr   = PW'(r_b_idx) + PW'(1);
                        n_left  = PW'(r_free_cnt) - PW'(r_b_idx) - PW'(1);
                        n_up    = 1'b0;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                c_issue = r_left != '0;
                if (c_issue) begin
                    n_v1   = 1'b1;
                    n_left = r_left - PW'(1);
                    n_ptr  = r_up ? (r_ptr - PW'(1)) : (r_ptr + PW'(1));
                end
                if (r_v1) begin
                    fr_we = 1'b1;
                    fr_wa = r_up ? FIW'(r_ridx + PW'(1)) : FIW'(r_ridx - PW'(1));
                    fr_wd = fr_rd;
                end
                if (!c_issue && !r_v1) begin
                    if (r_up) begin
                        n_state = S_FRE_INS;
                    end else begin
                        n_free_cnt = r_free_cnt - CNTW'(1);
                        n_state    = S_DONE;
                    end
                end
            end
            S_FRE_LOOK: begin
                c_issue = (r_ptr < PW'(LIVE_SLOTS)) && !r_found;
                if (c_issue) begin
                    n_ptr = r_ptr + PW'(1);
                    n_v1  = 1'b1;
                end
                if (r_v1 && !r_found && r_live_vld[r_ridx[LIW-1:0]] && (c_lv_off == r_addr)) begin
                    n_found    = 1'b1;
                    n_slot     = r_ridx[LIW-1:0];
                    n_blk_base = c_lv_base;
                    n_blk_len  = c_lv_len;
                end
                if (!c_issue && !r_v1) begin
                    if (r_found) begin
                        n_ptr   = '0;
                        n_state = S_FRE_FINDP;
                    end else begin
                        n_res_status = ST_UNKNOWN;
                        n_state      = S_DONE;
                    end
                end
            end
            S_FRE_FINDP: begin
                c_issue = (r_ptr < PW'(r_free_cnt)) && !r_pdone;
                if (c_issue) begin
                    n_ptr = r_ptr + PW'(1);
                    n_v1  = 1'b1;
                end
                if (r_v1 && !r_pdone) begin
                    if (c_fr_base < r_blk_base) begin
                        n_have_prev = 1'b1;
                        n_prev_base = c_fr_base;
                        n_prev_len  = c_fr_len;
                        n_p         = CNTW'(r_ridx + PW'(1));
                    end else begin
                        n_pdone     = 1'b1;
                        n_have_next = 1'b1;
                        n_next_base = c_fr_base;
                        n_next_len  = c_fr_len;
                        n_p         = CNTW'(r_ridx);
                    end
                end
                if (!c_issue && !r_v1) begin
                    n_state = S_FRE_DECIDE;
                end
            end
            S_FRE_DECIDE: begin
                if (c_join_prev || c_join_next || (r_free_cnt < CNTW'(FREE_SLOTS))) begin
                    n_live_vld[r_slot] = 1'b0;
                    n_used             = c_used_sub;
                    n_res_bytes        = r_blk_len;
                end
                if (c_join_prev && c_join_next) begin
                    fr_we   = 1'b1;
                    fr_wa   = FIW'(r_p - CNTW'(1));
                    fr_wd   = {r_prev_base, r_prev_len + r_blk_len + r_next_len};
                    n_ptr   = PW'(r_p) + PW'(1);
                    n_left  = PW'(r_free_cnt) - PW'(r_p) - PW'(1);
                    n_up    = 1'b0;
                    n_state = S_SHIFT;
                end else if (c_join_prev) begin
                    fr_we   = 1'b1;
                    fr_wa   = FIW'(r_p - CNTW'(1));
                    fr_wd   = {r_prev_base, r_prev_len + r_blk_len};
                    n_state = S_DONE;
                end else if (c_join_next) begin
                    fr_we   = 1'b1;
                    fr_wa   = FIW'(r_p);
                    fr_wd   = {r_blk_base, r_blk_len + r_next_len};
                    n_state = S_DONE;
                end else if (r_free_cnt < CNTW'(FREE_SLOTS)) begin
                    // Open a slot at the insert point, moving the tail up one entry.
                    n_ptr   = PW'(r_free_cnt) - PW'(1);
                    n_left  = PW'(r_free_cnt) - PW'(r_p);
                    n_up    = 1'b1;
                    n_state = S_SHIFT;
                end else begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end
            end
            S_FRE_INS: begin
                fr_we      = 1'b1;
                fr_wa      = FIW'(r_p);
                fr_wd      = {r_blk_base, r_blk_len};
                n_free_cnt = r_free_cnt + CNTW'(1);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_peak      = c_peak_max;
                    n_o_status  = r_res_status;
                    n_o_offset  = r_res_offset;
                    n_o_bytes   = r_res_bytes;
                    n_o_used    = r_used;
                    n_o_peak    = c_peak_max;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_region    <= SW'(REGION_RESET);
            r_free_cnt  <= CNTW'(1);
            r_live_vld  <= '0;
            r_used      <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_from_item <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_region <= i_cfg_wr_data;
            end
            r_free_cnt  <= n_free_cnt;
            r_live_vld  <= n_live_vld;
            r_used      <= n_used;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_v3        <= n_v3;
            r_from_item <= n_from_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_amask      <= n_amask;
        r_addr       <= n_addr;
        r_ptr        <= n_ptr;
        r_ridx       <= n_ridx;
        r_left       <= n_left;
        r_up         <= n_up;
        r_s2_idx     <= n_s2_idx;
        r_s2_base    <= n_s2_base;
        r_s2_len     <= n_s2_len;
        r_s2_align   <= n_s2_align;
        r_s3_idx     <= n_s3_idx;
        r_s3_base    <= n_s3_base;
        r_s3_len     <= n_s3_len;
        r_s3_align   <= n_s3_align;
        r_s3_need    <= n_s3_need;
        r_found      <= n_found;
        r_b_idx      <= n_b_idx;
        r_b_base     <= n_b_base;
        r_b_align    <= n_b_align;
        r_b_need     <= n_b_need;
        r_b_rest     <= n_b_rest;
        r_slot       <= n_slot;
        r_blk_base   <= n_blk_base;
        r_blk_len    <= n_blk_len;
        r_pdone      <= n_pdone;
        r_have_prev  <= n_have_prev;
        r_have_next  <= n_have_next;
        r_p          <= n_p;
        r_prev_base  <= n_prev_base;
        r_prev_len   <= n_prev_len;
        r_next_base  <= n_next_base;
        r_next_len   <= n_next_len;
        r_res_status <= n_res_status;
        r_res_offset <= n_res_offset;
        r_res_bytes  <= n_res_bytes;
        r_o_status   <= n_o_status;
        r_o_offset   <= n_o_offset;
        r_o_bytes    <= n_o_bytes;
        r_o_used     <= n_o_used;
        r_o_peak     <= n_o_peak;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_data_offset = r_o_offset;
    assign o_block_bytes = r_o_bytes;
    assign o_used_bytes  = r_o_used;
    assign o_peak_bytes  = r_o_peak;

`ifndef SYNTHESIS
    a_free_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CNTW'(FREE_SLOTS))
        else $error("free segment count exceeds the table size");

    a_used_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_used <= r_peak))
        else $error("used bytes above peak while idle");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("read pipeline busy while idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result presented outside the finish state");
`endif

endmodule

[tb/sv/bffla_checker.sv]
// Checker that predicts allocator results and compares them with the output channel.
`timescale 1ns / 1ps
module bffla_checker
    import bffla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [20:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [20:0] i_request_size,
    input  logic [3:0]  i_align_log2,
    input  logic [19:0] i_address,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [19:0] i_data_offset,
    input  logic [20:0] i_block_bytes,
    input  logic [20:0] i_used_bytes,
    input  logic [20:0] i_peak_bytes,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    localparam int NSEG = 32;
    localparam int NLIVE = 32;
    localparam int HDR = 8;
    localparam int MINSZ = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] offset;
        logic [20:0] bytes;
        logic [20:0] used;
        logic [20:0] peak;
    } t_result;

    t_result     expected_q[$];
    longint      seg_base[NSEG];
    longint      seg_len[NSEG];
    int          seg_count;
    longint      live_offset[NLIVE];
    longint      live_base[NLIVE];
    longint      live_size[NLIVE];
    bit          live_on[NLIVE];
    longint      used_sum;
    longint      peak_sum;
    longint      region_bytes;

    assign o_pending = expected_q.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic void restore_region();
        longint r;
        r = region_bytes > (64'd1 << 20) ? (64'd1 << 20) : region_bytes;
        for (int i = 0; i < NSEG; i++) begin
            seg_base[i] = 0;
            seg_len[i] = 0;
        end
        for (int i = 0; i < NLIVE; i++) live_on[i] = 0;
        seg_len[0] = r;
        seg_count = (r != 0) ? 1 : 0;
        used_sum = 0;
        peak_sum = 0;
    endfunction

    function automatic t_status allocate(input longint size, input int alog,
                                         output longint offset, output longint bytes);
        longint align, pad, need, rest, best_rest, best_need, best_pad;
        int best, slot;
        bit found;
        found = 0;
        best = 0;
        best_rest = 0;
        best_need = 0;
        best_pad = 0;
        offset = 0;
        bytes = 0;
        if (size < MINSZ || alog > MAX_ALIGN_LOG2) return ST_BAD_REQ;
        align = 64'd1 << alog;
        if (align < 8) align = 8;
        for (int i = 0; i < seg_count; i++) begin
            pad = ((seg_base[i] + HDR + align - 1) & ~(align - 1)) - seg_base[i];
            need = size + pad;
            if (seg_len[i] >= need) begin
                rest = seg_len[i] - need;
                if (!found || rest < best_rest) begin
                    found = 1;
                    best = i;
                    best_rest = rest;
                    best_need = need;
                    best_pad = pad;
                end
            end
        end
        if (!found) return ST_NO_FIT;
        slot = NLIVE;
        for (int s = NLIVE - 1; s >= 0; s--) if (!live_on[s]) slot = s;
        if (slot == NLIVE) return ST_FULL;
        live_on[slot] = 1;
        live_base[slot] = seg_base[best];
        live_size[slot] = best_need;
        live_offset[slot] = seg_base[best] + best_pad;
        offset = live_offset[slot];
        bytes = best_need;
        if (best_rest > 0) begin
            seg_base[best] += best_need;
            seg_len[best] = best_rest;
        end else begin
            for (int i = best; i + 1 < seg_count; i++) begin
                seg_base[i] = seg_base[i + 1];
                seg_len[i] = seg_len[i + 1];
            end
            seg_count--;
        end
        used_sum += best_need;
        if (used_sum > peak_sum) peak_sum = used_sum;
        return ST_OK;
    endfunction

    function automatic t_status release_block(input longint addr, output longint bytes);
        int slot, p;
        longint b, len;
        bit jp, jn;
        bytes = 0;
        slot = NLIVE;
        for (int s = NLIVE - 1; s >= 0; s--)
            if (live_on[s] && live_offset[s] == addr) slot = s;
        if (slot == NLIVE) return ST_UNKNOWN;
        b = live_base[slot];
        len = live_size[slot];
        p = 0;
        while (p < seg_count && seg_base[p] < b) p++;
        jp = p > 0 && seg_base[p - 1] + seg_len[p - 1] == b;
        jn = p < seg_count && b + len == seg_base[p];
        if (jp && jn) begin
            seg_len[p - 1] += len + seg_len[p];
            for (int i = p; i + 1 < seg_count; i++) begin
                seg_base[i] = seg_base[i + 1];
                seg_len[i] = seg_len[i + 1];
            end
            seg_count--;
        end else if (jp) begin
            seg_len[p - 1] += len;
        end else if (jn) begin
            seg_base[p] = b;
            seg_len[p] += len;
        end else begin
            if (seg_count >= NSEG) return ST_FULL;
            for (int i = seg_count; i > p; i--) begin
                seg_base[i] = seg_base[i - 1];
                seg_len[i] = seg_len[i - 1];
            end
            seg_base[p] = b;
            seg_len[p] = len;
            seg_count++;
        end
        live_on[slot] = 0;
        used_sum = used_sum >= len ? used_sum - len : 0;
        bytes = len;
        return ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        t_status st;
        longint off, nb;
        if (!i_rst_n) begin
            region_bytes = REGION_RESET;
            restore_region();
            expected_q.delete();
            o_fail_count = 0;
            o_results_seen = 0;
        end else begin
            if (i_cfg_wr_en) region_bytes = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                off = 0;
                nb = 0;
                st = ST_OK;
                case (t_kind'(i_kind))
                    KIND_ALLOC: st = allocate(i_request_size, i_align_log2, off, nb);
                    KIND_FREE:  st = release_block(i_address, nb);
                    KIND_RESET: restore_region();
                    default: ;
                endcase
                if (st != ST_OK) begin
                    off = 0;
                    nb = 0;
                end
                exp_r.status = st;
                exp_r.offset = off[19:0];
                exp_r.bytes = nb[20:0];
                exp_r.used = used_sum[20:0];
                exp_r.peak = peak_sum[20:0];
                expected_q.push_back(exp_r);
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_status !== exp_r.status)
                        report_mismatch("status", i_status, exp_r.status);
                    if (i_data_offset !== exp_r.offset)
                        report_mismatch("data_offset", i_data_offset, exp_r.offset);
                    if (i_block_bytes !== exp_r.bytes)
                        report_mismatch("block_bytes", i_block_bytes, exp_r.bytes);
                    if (i_used_bytes !== exp_r.used)
                        report_mismatch("used_bytes", i_used_bytes, exp_r.used);
                    if (i_peak_bytes !== exp_r.peak)
                        report_mismatch("peak_bytes", i_peak_bytes, exp_r.peak);
                end
            end
        end
    end
endmodule

[tb/sv/tb.sv]
// Testbench top: stimulus, configuration phases and verdict for the allocator.
`timescale 1ns / 1ps
module tb;
    import bffla_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [20:0] cfg_wr_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = KIND_ALLOC;
    logic [20:0] request_size = 0;
    logic [3:0]  align_log2 = 0;
    logic [19:0] address = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [19:0] data_offset;
    logic [20:0] block_bytes, used_bytes, peak_bytes;
    int          fail_count, pending, results_seen;
    int          idle_pct = 35;
    longint      cycle = 0;
    logic [19:0] issued_offsets[$];
    int          sent = 0;

    always #2 clk = ~clk;

    best_fit_free_list_allocator u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_request_size(request_size),
        .i_align_log2(align_log2), .i_address(address),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_data_offset(data_offset), .o_block_bytes(block_bytes),
        .o_used_bytes(used_bytes), .o_peak_bytes(peak_bytes)
    );

    bffla_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_kind(kind),
        .i_request_size(request_size), .i_align_log2(align_log2), .i_address(address),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_data_offset(data_offset), .i_block_bytes(block_bytes), .i_used_bytes(used_bytes),
        .i_peak_bytes(peak_bytes), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    // Remember offsets handed out so that frees mostly hit live allocations.
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (out_valid && !out_stall && status == ST_OK && data_offset != 0)
            issued_offsets.push_back(data_offset);
        if (issued_offsets.size() > 64) void'(issued_offsets.pop_front());
        out_stall <= ($urandom_range(99) < idle_pct);
        if (cycle > 3000000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Valid drops only on an idle cycle, so back-to-back transactions keep it high.
    task automatic send(input t_kind k, input int unsigned sz, input int unsigned al,
                        input int unsigned ad);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        request_size <= sz[20:0];
        align_log2 <= al[3:0];
        address <= ad[19:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_region(input int unsigned sz);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= sz[20:0];
        @(posedge clk);
        cfg_wr_en <= 0;
        send(KIND_RESET, 0, 0, 0);
    endtask

    task automatic random_item();
        int unsigned r, a;
        r = $urandom_range(99);
        if (r < 50) begin
            a = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12);
            case ($urandom_range(9))
                0: send(KIND_ALLOC, $urandom_range(21'h1FFFFF), a, 0);
                1: send(KIND_ALLOC, $urandom_range(15), a, 0);
                default: send(KIND_ALLOC, $urandom_range(16, 400), a, 0);
            endcase
        end else if (r < 90 && issued_offsets.size() > 0) begin
            a = $urandom_range(issued_offsets.size() - 1);
            send(KIND_FREE, 0, 0, issued_offsets[a]);
        end else if (r < 96) begin
            send(KIND_FREE, 0, 0, $urandom_range(20'hFFFFF));
        end else if (r < 98) begin
            send(KIND_SPARE, $urandom, $urandom, $urandom);
        end else begin
            send(KIND_RESET, 0, 0, 0);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes, every kind and each special case.
        send(KIND_ALLOC, 15, 0, 0);
        send(KIND_ALLOC, 16, 13, 0);
        send(KIND_ALLOC, 21'h1FFFFF, 15, 0);
        send(KIND_ALLOC, 16, 0, 0);
        send(KIND_ALLOC, 100, 12, 0);
        send(KIND_ALLOC, 16, 2, 0);
        send(KIND_ALLOC, 1048576, 3, 0);
        send(KIND_FREE, 0, 0, 8);
        send(KIND_FREE, 0, 0, 8);
        send(KIND_FREE, 0, 0, 20'hFFFFF);
        send(KIND_SPARE, 21'h1FFFFF, 4'hF, 20'hFFFFF);
        // Fill the live table, then the last three allocations find it full.
        for (int i = 0; i < 33; i++) send(KIND_ALLOC, 16, 0, 0);
        // Free at a stride of 48 bytes from offset 8; only the first address holds a live block.
        for (int i = 0; i < 16; i++) send(KIND_FREE, 0, 0, 8 + 48 * i);
        send(KIND_RESET, 0, 0, 0);

        write_region(64);
        send(KIND_ALLOC, 56, 0, 0);
        send(KIND_ALLOC, 16, 0, 0);
        write_region(0);
        send(KIND_ALLOC, 16, 0, 0);
        write_region(21'h1FFFFF);
        send(KIND_ALLOC, 1048568, 3, 0);
        send(KIND_FREE, 0, 0, 8);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_region(1048576);
                1: write_region(2048);
                2: write_region(65536);
                default: write_region(64);
            endcase
            idle_pct = (ph == 2) ? 0 : 35;
            for (int i = 0; i < 145; i++) begin
                random_item();
                if (ph == 1 && i == 80) drain();
            end
        end
        idle_pct = 35;

        drain();
        $display("Ran %0d transactions, %0d results, over regions 0 to 2^21-1.",
                 sent, results_seen);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
